### rtl/deq_pkg.sv
package deq_pkg;

  // command codes
  localparam logic [1:0] FN_PUSH_FRONT = 2'd0;
  localparam logic [1:0] FN_PUSH_REAR  = 2'd1;
  localparam logic [1:0] FN_POP_FRONT  = 2'd2;
  localparam logic [1:0] FN_POP_REAR   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // per-chain cell control, seen from the chain's own head end
  typedef struct packed {
    logic ins_head;  // shift towards the far end, insert at cell 0
    logic ins_tail;  // write into the first free cell
    logic del_head;  // shift towards cell 0
  } cell_ctl_t;

endpackage

### rtl/deq_cell.sv
module deq_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX   = 0
) (
  input  logic              clk,
  input  deq_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]  count,
  input  deq_pkg::data_t    ins_data,
  input  deq_pkg::data_t    prev_data,
  input  deq_pkg::data_t    next_data,
  output deq_pkg::data_t    data
);
  import deq_pkg::*;

  data_t data_r;
  data_t data_nxt;
  logic  is_tail_slot;

  // this cell is the first free slot of the chain
  assign is_tail_slot = (count == CNT_W'(IDX));

  // take from a neighbour or from the incoming value
  always_comb begin
    data_nxt = data_r;
    if (ctl.ins_head) begin
      data_nxt = prev_data;
    end else if (ctl.ins_tail && is_tail_slot) begin
      data_nxt = ins_data;
    end else if (ctl.del_head) begin
      data_nxt = next_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

### rtl/deq_chain.sv
module deq_chain #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = 5
) (
  input  logic               clk,
  input  deq_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   count,
  input  deq_pkg::data_t     ins_data,
  output deq_pkg::data_t     head_data
);
  import deq_pkg::*;

  data_t cell_data [DEPTH];

  // row of cells, cell 0 holds the head element
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    data_t prev_d;
    data_t next_d;

    if (i == 0) begin : g_first
      assign prev_d = ins_data;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_d = cell_data[i];
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end

    deq_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .ins_data  (ins_data),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_data[i])
    );
  end

  assign head_data = cell_data[0];

endmodule

### rtl/double_ended_queue_top.sv
// Bounded double-ended queue of DEPTH signed 32-bit entries. Each command
// (push front, push rear, pop front, pop rear) yields one registered result
// in the cycle after it is taken, and a new command is taken every cycle while the
// result side keeps up. The entries live in two mirrored rows of shifting
// cells, one with the front element in its first cell and one with the
// rear element in its first cell, so front, rear and popped values never
// need a wide read multiplexer. A push on a full queue is dropped with
// status full, a pop on an empty queue returns zero with status empty, and
// front and rear read zero whenever the queue holds nothing.
module double_ended_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_func,
  input  logic signed [31:0]            in_push_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_popped_value,
  output logic [1:0]                    out_status,
  output logic signed [31:0]            out_front_value,
  output logic signed [31:0]            out_rear_value,
  output logic [$clog2(DEPTH+1)-1:0]    out_entry_count,
  output logic                          out_is_empty
);
  import deq_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic             accept;
  logic             is_full;
  logic             is_empty;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  data_t            popped_r;
  data_t            popped_nxt;
  logic [1:0]       status_r;
  logic [1:0]       status_nxt;
  cell_ctl_t        front_ctl;
  cell_ctl_t        rear_ctl;
  data_t            front_head;
  data_t            rear_head;

  // take a transaction when the result register is free or being drained
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // decode the command into shift and write controls for both rows
  always_comb begin
    front_ctl  = '0;
    rear_ctl   = '0;
    count_nxt  = count_r;
    popped_nxt = popped_r;
    status_nxt = status_r;
    if (accept) begin
      popped_nxt = '0;
      status_nxt = ST_OK;
      case (in_func)
        FN_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            front_ctl.ins_head = 1'b1;
            rear_ctl.ins_tail  = 1'b1;
            count_nxt          = count_r + 1'b1;
          end
        end
        FN_PUSH_REAR: begin
          if (is_full) begin
            status_nxt = ST_FULL;
          end else begin
            rear_ctl.ins_head  = 1'b1;
            front_ctl.ins_tail = 1'b1;
            count_nxt          = count_r + 1'b1;
          end
        end
        FN_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            front_ctl.del_head = 1'b1;
            popped_nxt         = front_head;
            count_nxt          = count_r - 1'b1;
          end
        end
        FN_POP_REAR: begin
          if (is_empty) begin
            status_nxt = ST_EMPTY;
          end else begin
            rear_ctl.del_head = 1'b1;
            popped_nxt        = rear_head;
            count_nxt         = count_r - 1'b1;
          end
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end
  end

  // result register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (~out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

  // row with the front element in cell 0
  deq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front_chain (
    .clk       (clk),
    .ctl       (front_ctl),
    .count     (count_r),
    .ins_data  (in_push_value),
    .head_data (front_head)
  );

  // mirrored row with the rear element in cell 0
  deq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_rear_chain (
    .clk       (clk),
    .ctl       (rear_ctl),
    .count     (count_r),
    .ins_data  (in_push_value),
    .head_data (rear_head)
  );

  // the view only changes together with the result register
  assign out_valid        = out_valid_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_front_value  = is_empty ? '0 : front_head;
  assign out_rear_value   = is_empty ? '0 : rear_head;
  assign out_entry_count  = count_r;
  assign out_is_empty     = is_empty;

endmodule

### tb/tb_double_ended_queue_top.sv
module tb_double_ended_queue_top;
  import deq_pkg::*;

  localparam int DEPTH = 16;
  localparam int COUNT_W = $clog2(DEPTH + 1);
  localparam int CYCLE_LIMIT = 200000;

  // predicted view of the deque after one command
  typedef struct packed {
    data_t              popped;
    logic [1:0]         status;
    data_t              front;
    data_t              rear;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } deque_view_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_func = FN_PUSH_FRONT;
  data_t              in_push_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  data_t              out_popped_value;
  logic [1:0]         out_status;
  data_t              out_front_value;
  data_t              out_rear_value;
  logic [COUNT_W-1:0] out_entry_count;
  logic               out_is_empty;

  // mirror of the deque contents
  data_t mirror_store [DEPTH];
  int    mirror_head = 0;
  int    mirror_tail = 0;
  int    mirror_count = 0;

  deque_view_t result_view_q [$];
  bit          mismatch_seen = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          cycle_count = 0;

  double_ended_queue_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_push_value   (in_push_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_popped_value(out_popped_value),
    .out_status      (out_status),
    .out_front_value (out_front_value),
    .out_rear_value  (out_rear_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  always #5 clk = ~clk;

  // apply one command to the mirror and return the view it should produce
  function automatic deque_view_t mirror_command(logic [1:0] func, data_t value);
    deque_view_t view;
    view = '0;
    view.status = ST_OK;
    case (func)
      FN_PUSH_FRONT, FN_PUSH_REAR: begin
        if (mirror_count >= DEPTH) begin
          view.status = ST_FULL;
        end else if (func == FN_PUSH_FRONT) begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_store[mirror_head] = value;
          mirror_count++;
        end else begin
          mirror_store[mirror_tail] = value;
          mirror_tail = (mirror_tail + 1) % DEPTH;
          mirror_count++;
        end
      end
      FN_POP_FRONT: begin
        if (mirror_count == 0) begin
          view.status = ST_EMPTY;
        end else begin
          view.popped = mirror_store[mirror_head];
          mirror_head = (mirror_head + 1) % DEPTH;
          mirror_count--;
        end
      end
      default: begin
        if (mirror_count == 0) begin
          view.status = ST_EMPTY;
        end else begin
          mirror_tail = (mirror_tail + DEPTH - 1) % DEPTH;
          view.popped = mirror_store[mirror_tail];
          mirror_count--;
        end
      end
    endcase
    // front and rear read zero on an empty deque
    if (mirror_count != 0) begin
      view.front = mirror_store[mirror_head];
      view.rear = mirror_store[(mirror_tail + DEPTH - 1) % DEPTH];
    end
    view.count = COUNT_W'(mirror_count);
    view.empty = (mirror_count == 0);
    return view;
  endfunction

  // present one command, hold it until taken, then record its prediction
  task automatic send_cmd(input logic [1:0] func, input data_t value);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_push_value <= value;
    do @(posedge clk); while (in_stall);
    result_view_q.push_back(mirror_command(func, value));
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // compare each result transaction against the oldest prediction
  always @(posedge clk) begin : check_results
    deque_view_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (result_view_q.size() == 0) begin
        $error("result transaction with no command outstanding");
        mismatch_seen = 1'b1;
      end else begin
        want = result_view_q.pop_front();
        if (out_popped_value !== want.popped) begin
          $error("popped_value: expected %0d, got %0d", want.popped, out_popped_value);
          mismatch_seen = 1'b1;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          mismatch_seen = 1'b1;
        end
        if (out_front_value !== want.front) begin
          $error("front_value: expected %0d, got %0d", want.front, out_front_value);
          mismatch_seen = 1'b1;
        end
        if (out_rear_value !== want.rear) begin
          $error("rear_value: expected %0d, got %0d", want.rear, out_rear_value);
          mismatch_seen = 1'b1;
        end
        if (out_entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, out_entry_count);
          mismatch_seen = 1'b1;
        end
        if (out_is_empty !== want.empty) begin
          $error("is_empty: expected %0d, got %0d", want.empty, out_is_empty);
          mismatch_seen = 1'b1;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // pops on the empty deque at both ends
  task automatic test_pop_on_empty();
    send_cmd(FN_POP_FRONT, 32'sh7fff_ffff);
    send_cmd(FN_POP_REAR, 32'sh8000_0000);
  endtask

  // fill from both ends so the head index wraps past the start of the store
  task automatic test_fill_with_wrap();
    data_t pattern [6];
    pattern = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1,
                32'sh5555_5555, 32'shaaaa_aaaa};
    for (int i = 0; i < DEPTH; i++) begin
      send_cmd((i % 2 == 0) ? FN_PUSH_FRONT : FN_PUSH_REAR, pattern[i % 6]);
    end
  endtask

  // pushes on a full deque are dropped
  task automatic test_push_on_full();
    send_cmd(FN_PUSH_REAR, 32'sh1234_5678);
    send_cmd(FN_PUSH_FRONT, -32'sd2);
  endtask

  task automatic test_pop_both_ends();
    send_cmd(FN_POP_FRONT, '0);
    send_cmd(FN_POP_REAR, -32'sd1);
  endtask

  // biased bursts push the deque repeatedly into full and empty
  task automatic test_random_traffic(input int n_items);
    int         burst_left;
    int         push_pct;
    logic [1:0] func;
    data_t      value;
    burst_left = 0;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 15;
          default: push_pct = 50;
        endcase
        burst_left = $urandom_range(40, 6);
      end
      burst_left--;
      if ($urandom_range(99) < push_pct) begin
        func = $urandom_range(1) ? FN_PUSH_REAR : FN_PUSH_FRONT;
      end else begin
        func = $urandom_range(1) ? FN_POP_REAR : FN_POP_FRONT;
      end
      case ($urandom_range(7))
        0: value = 32'sh8000_0000;
        1: value = 32'sh7fff_ffff;
        2: value = '0;
        3: value = -32'sd1;
        default: value = $urandom;
      endcase
      send_cmd(func, value);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 19;
    recv_idle_pct = 71;
    test_pop_on_empty();
    test_fill_with_wrap();
    test_push_on_full();
    test_pop_both_ends();
    test_random_traffic(276);

    // sender mostly idle, receiver mostly ready
    send_idle_pct = 71;
    recv_idle_pct = 19;
    test_random_traffic(276);

    // back to back, no idling
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(276);

    @(negedge clk);
    in_valid <= 1'b0;
    while (result_view_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (!mismatch_seen) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
